/* rtl/core/assert_macros.svh */
// assertion macros of the gain processor rtl, used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SRGP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srgp assertion failed");

// antecedent implies consequent in the same cycle
`define SRGP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srgp assertion failed");

`else

`define SRGP_ASSERT(name, prop)
`define SRGP_ASSERT_IMPL(name, ante, cons)

`endif

`endif

/* rtl/core/srgp_pkg.sv */
// shared types, constants and helper functions of the sample range gain processor
package srgp_pkg;

  localparam int unsigned MaxRangeBitsDef = 24;
  localparam int unsigned GainFracBitsDef = 16;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned ScaleW          = 32;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 3;

  localparam logic signed [15:0] SatPos = 16'sd32767;
  localparam logic signed [15:0] SatNeg = -16'sd32767;

  typedef enum logic [2:0] {
    MODE_DC       = 3'd0,
    MODE_NORM     = 3'd1,
    MODE_ZERO     = 3'd2,
    MODE_FADE_IN  = 3'd3,
    MODE_FADE_OUT = 3'd4,
    MODE_HALF     = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 2'd0,
    CFG_STEREO = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_MEAN_L = 2'd0,
    DIV_MEAN_R = 2'd1,
    DIV_STEP   = 2'd2,
    DIV_SCALE  = 2'd3
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DIV_START = 3'd1,
    ST_DIV_RUN   = 3'd2,
    ST_MUL_L     = 3'd3,
    ST_MUL_R     = 3'd4,
    ST_FINISH    = 3'd5
  } state_e;

  typedef struct packed {
    logic               command;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_out;
    logic               zero_peak;
  } out_item_t;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    div_op_e div_op;
    logic    div_capture;
    logic    derive_done;
    logic    mul_en;
    logic    mul_right;
    logic    fin_left;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic derived_ready;
    logic div_done;
  } dp_sts_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] sat_sample(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = SatPos;
    end else if (v < -18'sd32767) begin
      r = SatNeg;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/srgp_div.sv */
// restoring divider, one quotient bit per cycle
module srgp_div #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, acc_q[DVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      acc_d = {acc_q[DVD_W-2:0], fits};
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

/* rtl/core/srgp_dp.sv */
// datapath: range statistics, derived gains, shared multiplier and output register
module srgp_dp import srgp_pkg::*; #(
  parameter int unsigned MAX_RANGE_BITS = MaxRangeBitsDef,
  parameter int unsigned GAIN_FRAC_BITS = GainFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  in_item_t            in_data_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW  = MAX_RANGE_BITS + 1;
  localparam int unsigned SumW  = MAX_RANGE_BITS + SampleW;
  localparam int unsigned GainW = GAIN_FRAC_BITS + 1;
  localparam int unsigned DivW  = (SumW > GAIN_FRAC_BITS + 16) ? SumW : GAIN_FRAC_BITS + 16;
  localparam int unsigned DvsW  = (CntW > SampleW) ? CntW : SampleW;
  localparam int unsigned ProdW = SampleW + ScaleW;

  localparam logic [GainW-1:0] Unity = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  // configuration
  logic [2:0] mode_q;
  logic       stereo_q;

  // range statistics and derived values
  logic signed [SumW-1:0] sum_l_q, sum_r_q, sum_l_d, sum_r_d, sum_l_base, sum_r_base;
  logic [15:0]            peak_q, peak_d, peak_base;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt_base;
  logic signed [15:0]     mean_l_q, mean_r_q;
  logic [ScaleW-1:0]      scale_q;
  logic [GainW-1:0]       step_q, gain_q;
  logic                   ready_q;
  logic [15:0]            abs_l, abs_r;
  logic                   analyze;

  // per item payload
  logic signed [15:0] smp_l_q, smp_r_q;
  logic               last_q;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic signed [15:0] lres_q;
  out_item_t          out_q;

  // divider
  logic [DivW-1:0]   dvd;
  logic [DvsW-1:0]   dvs;
  logic [SumW-1:0]   mag_l, mag_r;
  logic              div_done;
  logic [DivW-1:0]   quo;
  logic [ScaleW-1:0] scale_sat;
  logic              cnt_zero, peak_zero;

  // multiply and finish
  logic signed [15:0] mul_s, fin_s, fin_mean, fin_v, scaled;
  logic [15:0]        mul_mag, scaled_pos;
  logic [ScaleW-1:0]  gain_sel;
  logic [ProdW-1:0]   shifted;
  logic [14:0]        scaled_mag;
  logic signed [17:0] half_v;
  logic [GainW:0]     gain_sum;

  assign cnt_zero  = (cnt_q == '0);
  assign peak_zero = (peak_q == '0);
  assign analyze   = cmd_i.accept && !in_data_i.command;

  // analyze pass: a new range starts once derived values exist
  always_comb begin
    sum_l_base = ready_q ? '0 : sum_l_q;
    sum_r_base = ready_q ? '0 : sum_r_q;
    peak_base  = ready_q ? '0 : peak_q;
    cnt_base   = ready_q ? '0 : cnt_q;
    abs_l      = abs16(in_data_i.left_in);
    abs_r      = abs16(in_data_i.right_in);
    sum_l_d    = sum_l_base;
    sum_r_d    = sum_r_base;
    peak_d     = peak_base;
    cnt_d      = cnt_base;
    if (!cnt_base[CntW-1]) begin
      sum_l_d = sum_l_base + SumW'(in_data_i.left_in);
      if (abs_l > peak_d) begin
        peak_d = abs_l;
      end
      if (stereo_q) begin
        sum_r_d = sum_r_base + SumW'(in_data_i.right_in);
        if (abs_r > peak_d) begin
          peak_d = abs_r;
        end
      end
      cnt_d = cnt_base + CntW'(1);
    end
  end

  // divider operands
  always_comb begin
    mag_l = sum_l_q[SumW-1] ? SumW'(-sum_l_q) : SumW'(sum_l_q);
    mag_r = sum_r_q[SumW-1] ? SumW'(-sum_r_q) : SumW'(sum_r_q);
    case (cmd_i.div_op)
      DIV_MEAN_L: begin
        dvd = DivW'(mag_l);
        dvs = DvsW'(cnt_q);
      end
      DIV_MEAN_R: begin
        dvd = DivW'(mag_r);
        dvs = DvsW'(cnt_q);
      end
      DIV_STEP: begin
        dvd = DivW'({1'b1, {GAIN_FRAC_BITS{1'b0}}});
        dvs = DvsW'(cnt_q);
      end
      DIV_SCALE: begin
        dvd = DivW'({1'b1, {(GAIN_FRAC_BITS + 15){1'b0}}});
        dvs = DvsW'(peak_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  srgp_div #(
    .DVD_W(DivW),
    .DVS_W(DvsW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  generate
    if (DivW > ScaleW) begin : g_scale_sat
      assign scale_sat = (|quo[DivW-1:ScaleW]) ? '1 : quo[ScaleW-1:0];
    end else begin : g_scale_fit
      assign scale_sat = ScaleW'(quo);
    end
  endgenerate

  // shared multiplier: magnitude times gain
  always_comb begin
    mul_s   = cmd_i.mul_right ? smp_r_q : smp_l_q;
    mul_mag = abs16(mul_s);
    case (mode_q)
      MODE_NORM:     gain_sel = scale_q;
      MODE_FADE_IN:  gain_sel = ScaleW'(gain_q);
      MODE_FADE_OUT: gain_sel = ScaleW'(Unity - gain_q);
      default:       gain_sel = '0;
    endcase
    prod_d = ProdW'(mul_mag) * ProdW'(gain_sel);
  end

  // finish stage: turns the registered product or the sample into a result
  always_comb begin
    fin_s      = cmd_i.fin_left ? smp_l_q : smp_r_q;
    fin_mean   = cmd_i.fin_left ? mean_l_q : mean_r_q;
    shifted    = prod_q >> GAIN_FRAC_BITS;
    scaled_mag = (|shifted[ProdW-1:15]) ? 15'h7fff : shifted[14:0];
    scaled_pos = {1'b0, scaled_mag};
    scaled     = fin_s[15] ? 16'(~scaled_pos + 16'd1) : scaled_pos;
    half_v     = fin_s[15] ? ((18'(fin_s) + 18'sd1) >>> 1) : (18'(fin_s) >>> 1);
    case (mode_q)
      MODE_DC:       fin_v = sat_sample(18'(fin_s) - 18'(fin_mean));
      MODE_NORM:     fin_v = peak_zero ? sat_sample(18'(fin_s)) : scaled;
      MODE_ZERO:     fin_v = '0;
      MODE_FADE_IN:  fin_v = scaled;
      MODE_FADE_OUT: fin_v = scaled;
      MODE_HALF:     fin_v = sat_sample(half_v);
      default:       fin_v = sat_sample(18'(fin_s));
    endcase
    gain_sum = {1'b0, gain_q} + {1'b0, step_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DC;
      stereo_q <= 1'b0;
      sum_l_q  <= '0;
      sum_r_q  <= '0;
      peak_q   <= '0;
      cnt_q    <= '0;
      mean_l_q <= '0;
      mean_r_q <= '0;
      scale_q  <= '0;
      step_q   <= '0;
      gain_q   <= '0;
      ready_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) begin
          mode_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_STEREO) begin
          stereo_q <= cfg_data_i[0];
        end
      end
      if (analyze) begin
        sum_l_q <= sum_l_d;
        sum_r_q <= sum_r_d;
        peak_q  <= peak_d;
        cnt_q   <= cnt_d;
        ready_q <= 1'b0;
      end
      if (cmd_i.div_capture) begin
        case (cmd_i.div_op)
          DIV_MEAN_L: mean_l_q <= cnt_zero ? '0 :
                                  (sum_l_q[SumW-1] ? 16'(~quo[15:0] + 16'd1) : quo[15:0]);
          DIV_MEAN_R: mean_r_q <= cnt_zero ? '0 :
                                  (sum_r_q[SumW-1] ? 16'(~quo[15:0] + 16'd1) : quo[15:0]);
          DIV_STEP:   step_q   <= cnt_zero ? '0 : quo[GainW-1:0];
          DIV_SCALE:  scale_q  <= peak_zero ? '0 : scale_sat;
          default:    ;
        endcase
      end
      if (cmd_i.derive_done) begin
        ready_q <= 1'b1;
        gain_q  <= '0;
      end else if (cmd_i.out_load) begin
        // ramp advances on every process item and restarts after the last one
        if (last_q) begin
          gain_q <= '0;
        end else if (gain_sum > (GainW + 1)'(Unity)) begin
          gain_q <= Unity;
        end else begin
          gain_q <= gain_sum[GainW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_l_q <= in_data_i.left_in;
      smp_r_q <= in_data_i.right_in;
      last_q  <= in_data_i.last_in;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fin_left) begin
      lres_q <= fin_v;
    end
    if (cmd_i.out_load) begin
      out_q.left_out  <= lres_q;
      out_q.right_out <= stereo_q ? fin_v : 16'sd0;
      out_q.last_out  <= last_q;
      out_q.zero_peak <= (mode_q == MODE_NORM) && peak_zero;
    end
  end

  assign sts_o.derived_ready = ready_q;
  assign sts_o.div_done      = div_done;
  assign out_data_o          = out_q;

endmodule

/* rtl/core/srgp_ctrl.sv */
// controller: sequences analysis, division, multiply and output load
`include "assert_macros.svh"

module srgp_ctrl import srgp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_process_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e  state_q, state_d;
  div_op_e op_q, op_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    accept;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    op_d        = op_q;
    out_free    = !out_valid_q || out_ready_i;
    in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && out_free);
    accept      = in_valid_i && in_ready_o;
    cmd_o.accept = accept;
    cmd_o.div_op = op_q;
    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (sts_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          if (op_q == DIV_SCALE) begin
            cmd_o.derive_done = 1'b1;
            state_d           = ST_MUL_L;
          end else begin
            op_d    = div_op_e'(op_q + 2'd1);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_MUL_L: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_MUL_R;
      end
      ST_MUL_R: begin
        // right product goes in while the left result is finished
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_right = 1'b1;
        cmd_o.fin_left  = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (accept && in_process_i) begin
      state_d = sts_i.derived_ready ? ST_MUL_L : ST_DIV_START;
      op_d    = DIV_MEAN_L;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= DIV_MEAN_L;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SRGP_ASSERT_IMPL(a_mul_needs_derived, state_q == ST_MUL_L, sts_i.derived_ready)
  `SRGP_ASSERT_IMPL(a_div_done_in_run, sts_i.div_done, state_q == ST_DIV_RUN)
  // finish is entered only from the right multiply or held in place
  `SRGP_ASSERT_IMPL(a_finish_after_mul, state_q == ST_FINISH, $past(state_q) >= ST_MUL_R)

endmodule

/* rtl/core/sample_range_gain_processor.sv */
// top level of the sample range gain processor
// Usage:
// - in channel (in_valid_i / in_ready_o / in_data_i) carries sample items; command 0
//   items feed the analyze pass, command 1 items the process pass
// - an analyze item yields no result
// - a process item yields one result on the out channel (out_valid_o / out_ready_i)
//   after the states MUL_L, MUL_R and FINISH; the next item can be taken as that result
//   is loaded, the shared 16x32 multiplier taking left and right in turn
// - the first process item after an analyze pass first runs four divisions
//   (two means, fade step, normalize scale) on one bit-serial divider
// - config channel (cfg_valid_i / cfg_index_i / cfg_data_i) sets mode and stereo,
//   always ready; write it only while the block is idle
// - reset clears config, range statistics and derived values
// - the output register holds a result while the receiver stalls; the next item
//   is still taken and worked up to its output load, which then waits
module sample_range_gain_processor import srgp_pkg::*; #(
  parameter int unsigned MAX_RANGE_BITS = MaxRangeBitsDef,
  parameter int unsigned GAIN_FRAC_BITS = GainFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  srgp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_process_i(in_data_i.command),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srgp_dp #(
    .MAX_RANGE_BITS(MAX_RANGE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

/* tb/sv/sample_range_gain_processor_tb.sv */
// self-checking testbench of the sample range gain processor
`timescale 1ns / 100ps

module sample_range_gain_processor_tb import srgp_pkg::*;;

  localparam int     GainFrac    = GainFracBitsDef;
  localparam longint Unity       = longint'(1) << GainFrac;
  localparam longint RangeCap    = longint'(1) << MaxRangeBitsDef;
  localparam int     RandomItems = 1600;
  localparam int     QuietItems  = 200;
  localparam int     SettleGap   = 16;
  localparam int     DrainGap    = 200;
  localparam int     HoldCycles  = 1000;
  localparam int     LimitCycles = 2_000_000;
  localparam int     ShownFaults = 10;

  localparam logic CmdAnalyze = 1'b0;
  localparam logic CmdProcess = 1'b1;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    in_item_t              smp;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // predictor copy of the block state and registers
  logic signed [39:0] acc_l      = '0;
  logic signed [39:0] acc_r      = '0;
  logic [15:0]        peak_mag   = '0;
  logic [24:0]        n_samples  = '0;
  logic signed [15:0] avg_l      = '0;
  logic signed [15:0] avg_r      = '0;
  logic [31:0]        norm_scale = '0;
  logic [16:0]        fade_gain  = '0;
  logic [16:0]        fade_step  = '0;
  bit                 stats_valid = 1'b0;
  logic [2:0]         cur_mode   = MODE_DC;
  bit                 cur_stereo = 1'b0;

  out_item_t awaited_samples[$];
  dir_row_t  plan[$];
  int        fault_cnt   = 0;
  int        random_sent = 0;
  int        cycle_cnt   = 0;
  int        hold_left   = 0;
  int        stall_left  = 0;
  bit        tx_idle_on  = 1'b1;
  bit        rx_idle_on  = 1'b1;
  out_item_t head_exp;

  sample_range_gain_processor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // trunc(s * g / 2^frac) toward zero
  function automatic longint scaled(input int s, input longint g);
    longint mag;
    longint q;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    q = (mag * g) >> GainFrac;
    return (s < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] shape_channel(input logic signed [15:0] smp,
                                                        input logic signed [15:0] avg);
    int     s;
    longint v;
    s = smp;
    case (cur_mode)
      MODE_DC:       v = longint'(s) - longint'(avg);
      MODE_NORM:     v = (peak_mag == 0) ? longint'(s) : scaled(s, longint'(norm_scale));
      MODE_ZERO:     v = 0;
      MODE_FADE_IN:  v = scaled(s, longint'(fade_gain));
      MODE_FADE_OUT: v = scaled(s, Unity - longint'(fade_gain));
      MODE_HALF:     v = s / 2;
      default:       v = s;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return 16'(v);
  endfunction

  // means, fade step and normalize scale from the range totals
  function automatic void derive_range();
    longint q;
    if (n_samples != 0) begin
      avg_l     = 16'(longint'(acc_l) / longint'(n_samples));
      avg_r     = 16'(longint'(acc_r) / longint'(n_samples));
      fade_step = 17'(Unity / longint'(n_samples));
    end else begin
      avg_l     = '0;
      avg_r     = '0;
      fade_step = '0;
    end
    if (peak_mag != 0) begin
      q = (longint'(1) << (15 + GainFrac)) / longint'(peak_mag);
      norm_scale = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
    end else begin
      norm_scale = '0;
    end
    fade_gain   = '0;
    stats_valid = 1'b1;
  endfunction

  function automatic bit predict_gain_out(input in_item_t it, output out_item_t res);
    int     mag;
    longint g;
    res = '0;
    if (it.command == CmdAnalyze) begin
      // an analyze item after a derived range opens a new range
      if (stats_valid) begin
        acc_l = '0; acc_r = '0; peak_mag = '0; n_samples = '0;
        avg_l = '0; avg_r = '0; norm_scale = '0;
        fade_gain = '0; fade_step = '0; stats_valid = 1'b0;
      end
      if (longint'(n_samples) < RangeCap) begin
        acc_l += it.left_in;
        mag = it.left_in;
        if (mag < 0) mag = -mag;
        if (mag > peak_mag) peak_mag = 16'(mag);
        if (cur_stereo) begin
          acc_r += it.right_in;
          mag = it.right_in;
          if (mag < 0) mag = -mag;
          if (mag > peak_mag) peak_mag = 16'(mag);
        end
        n_samples++;
      end
      return 1'b0;
    end
    if (!stats_valid) derive_range();
    res.left_out  = shape_channel(it.left_in, avg_l);
    res.right_out = cur_stereo ? shape_channel(it.right_in, avg_r) : '0;
    res.last_out  = it.last_in;
    res.zero_peak = (cur_mode == MODE_NORM) && (peak_mag == 0);
    if (it.last_in) begin
      fade_gain = '0;
    end else begin
      g = longint'(fade_gain) + longint'(fade_step);
      fade_gain = 17'((g > Unity) ? Unity : g);
    end
    return 1'b1;
  endfunction

  function automatic void plan_item(input logic cmd, input int l, input int r,
                                    input logic last, input bit typed = 1'b0,
                                    input int lo = 0, input int ro = 0,
                                    input logic lasto = 1'b0, input logic zp = 1'b0);
    dir_row_t row;
    row.kind           = ROW_ITEM;
    row.reg_idx        = CFG_MODE;
    row.reg_val        = '0;
    row.smp.command    = cmd;
    row.smp.left_in    = 16'(l);
    row.smp.right_in   = 16'(r);
    row.smp.last_in    = last;
    row.typed          = typed;
    row.want.left_out  = 16'(lo);
    row.want.right_out = 16'(ro);
    row.want.last_out  = lasto;
    row.want.zero_peak = zp;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    dir_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, smp: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7fff;
      2:       v = 16'(int'($urandom_range(0, 8)) - 4);
      3:       v = '0;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // modes 0..5 twice as often as the two spare codes
  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 13);
    if (r < 6) return 3'(r);
    if (r < 12) return 3'(r - 6);
    return (r == 12) ? ModeSpare6 : ModeSpare7;
  endfunction

  task automatic send_item(input in_item_t it, input bit use_fixed, input out_item_t fixed);
    int        gap;
    out_item_t calc;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_gain_out(it, calc)) awaited_samples.push_back(use_fixed ? fixed : calc);
  endtask

  task automatic send_sample(input logic cmd, input logic last);
    in_item_t it;
    it.command  = cmd;
    it.left_in  = pick_sample();
    it.right_in = pick_sample();
    it.last_in  = last;
    send_item(it, 1'b0, '0);
    random_sent++;
  endtask

  // wait until the block has delivered everything and gone quiet
  task automatic settle(input int gap);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_samples.size() != 0) @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    settle(SettleGap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_MODE) cur_mode = val;
    else cur_stereo = val[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_samples.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= ShownFaults)
          $display("unexpected item: l=%0d r=%0d last=%0b zp=%0b", out_data_o.left_out,
                   out_data_o.right_out, out_data_o.last_out, out_data_o.zero_peak);
      end else begin
        head_exp = awaited_samples.pop_front();
        if (out_data_o.left_out !== head_exp.left_out ||
            out_data_o.right_out !== head_exp.right_out ||
            out_data_o.last_out !== head_exp.last_out ||
            out_data_o.zero_peak !== head_exp.zero_peak) begin
          fault_cnt++;
          if (fault_cnt <= ShownFaults)
            $display("mismatch: exp l=%0d r=%0d last=%0b zp=%0b, got l=%0d r=%0d last=%0b zp=%0b",
                     head_exp.left_out, head_exp.right_out, head_exp.last_out,
                     head_exp.zero_peak, out_data_o.left_out, out_data_o.right_out,
                     out_data_o.last_out, out_data_o.zero_peak);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL sample_range_gain_processor");
    $finish;
  end

  initial begin
    int phase;
    int span;
    int cut;
    int passes;
    bit drop_last;

    // empty range right after reset: means are zero
    plan_item(CmdProcess, -32768, 32767, 1'b0, 1'b1, -32767, 0, 1'b0, 1'b0);
    plan_item(CmdProcess, 32767, -1, 1'b1, 1'b1, 32767, 0, 1'b1, 1'b0);
    plan_cfg(CFG_STEREO, 3'd1);
    plan_cfg(CFG_MODE, MODE_NORM);
    // zero peak passes the sample through
    plan_item(CmdProcess, 32767, -32768, 1'b1, 1'b1, 32767, -32767, 1'b1, 1'b1);
    plan_item(CmdAnalyze, -32768, 100, 1'b0);
    plan_item(CmdAnalyze, 5, -7, 1'b1);
    // peak 32768 gives unity scale, then saturation
    plan_item(CmdProcess, -32768, 32767, 1'b0, 1'b1, -32767, 32767, 1'b0, 1'b0);
    plan_item(CmdProcess, 1, -1, 1'b1);
    plan_cfg(CFG_MODE, MODE_DC);
    plan_item(CmdProcess, 0, 0, 1'b1);
    plan_cfg(CFG_MODE, MODE_FADE_IN);
    plan_item(CmdAnalyze, 32767, -32768, 1'b0);
    plan_item(CmdAnalyze, 1000, -1000, 1'b0);
    plan_item(CmdAnalyze, -5, 5, 1'b0);
    plan_item(CmdAnalyze, 0, 0, 1'b1);
    plan_item(CmdProcess, 20000, -20000, 1'b0);
    plan_item(CmdProcess, 32767, -32768, 1'b0);
    plan_item(CmdProcess, -32768, 32767, 1'b0);
    plan_item(CmdProcess, 12345, -12345, 1'b1);
    // second process pass over the same analysis
    plan_cfg(CFG_MODE, MODE_FADE_OUT);
    plan_item(CmdProcess, 32767, -32768, 1'b0);
    plan_item(CmdProcess, -32768, 32767, 1'b1);
    plan_cfg(CFG_MODE, MODE_HALF);
    plan_item(CmdProcess, -32768, 32767, 1'b0, 1'b1, -16384, 16383, 1'b0, 1'b0);
    plan_item(CmdProcess, -1, 1, 1'b1, 1'b1, 0, 0, 1'b1, 1'b0);
    plan_cfg(CFG_MODE, MODE_ZERO);
    plan_item(CmdProcess, 32767, -32768, 1'b1, 1'b1, 0, 0, 1'b1, 1'b0);
    // spare mode codes pass through with saturation
    plan_cfg(CFG_MODE, ModeSpare6);
    plan_item(CmdProcess, -32768, 32767, 1'b0, 1'b1, -32767, 32767, 1'b0, 1'b0);
    plan_cfg(CFG_MODE, ModeSpare7);
    plan_item(CmdProcess, 123, -32768, 1'b1, 1'b1, 123, -32767, 1'b1, 1'b0);
    // mono range: right channel kept out of the peak
    plan_cfg(CFG_STEREO, 3'd0);
    plan_cfg(CFG_MODE, MODE_NORM);
    plan_item(CmdAnalyze, 3, -30000, 1'b1);
    plan_item(CmdProcess, 3, -30000, 1'b0, 1'b1, 32767, 0, 1'b0, 1'b0);
    plan_item(CmdProcess, -2, 5, 1'b1);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) write_reg(plan[k].reg_idx, plan[k].reg_val);
      else send_item(plan[k].smp, plan[k].typed, plan[k].want);
    end

    phase = 0;
    while (random_sent < RandomItems) begin
      if (random_sent >= RandomItems - QuietItems) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        write_reg(CFG_MODE, pick_mode());
        write_reg(CFG_STEREO, 3'($urandom_range(0, 1)));
      end
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      if (phase == 4) begin
        // receiver holds off while the sender keeps offering items
        settle(SettleGap);
        hold_left = HoldCycles;
        span = 60;
      end
      if (phase != 4 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_sample(1'($urandom), 1'($urandom));
      end else begin
        for (int i = 0; i < span; i++) send_sample(CmdAnalyze, i == span - 1);
        if ($urandom_range(0, 5) == 0) write_reg(CFG_MODE, pick_mode());
        passes = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
        repeat (passes) begin
          cut = span;
          drop_last = 1'b0;
          if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, span);
            drop_last = $urandom_range(0, 1);
          end
          for (int i = 0; i < cut; i++)
            send_sample(CmdProcess, (i == cut - 1) && !drop_last);
        end
      end
      phase++;
    end

    settle(DrainGap);
    if (fault_cnt == 0 && awaited_samples.size() == 0) begin
      $display("PASS sample_range_gain_processor");
    end else begin
      $display("FAIL sample_range_gain_processor");
    end
    $finish;
  end

endmodule
